>>> rtl/chaos_game_density_grid_assert.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef CHAOS_GAME_DENSITY_GRID_ASSERT_SVH
`define CHAOS_GAME_DENSITY_GRID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGDG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGDG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cgdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cgdg_pkg;

  // Default geometry and counter width.
  localparam int GRID_WIDTH_DEF  = 20;
  localparam int GRID_HEIGHT_DEF = 20;
  localparam int COUNT_BITS_DEF  = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 3'd5;

  // Register reset values.
  localparam logic [7:0]  WEIGHT_RST = 8'd1;
  localparam logic [3:0]  NUM_RST    = 4'd1;
  localparam logic [3:0]  DEN_RST    = 4'd2;
  localparam logic [15:0] WARMUP_RST = 16'd10;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Vertex codes.
  localparam logic [1:0] VTX_LEFT  = 2'd0;
  localparam logic [1:0] VTX_RIGHT = 2'd1;
  localparam logic [1:0] VTX_TOP   = 2'd2;

  localparam int LEVEL_MAX = 9;
  localparam logic [6:0] GLYPH_SPACE = 7'h20;
  localparam logic [6:0] GLYPH_HASH  = 7'h23;

  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] random_word;
    logic [4:0]  cell_row;
    logic [4:0]  cell_col;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         chosen_vertex;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               plotted;
    logic [15:0]        cell_hits;
    logic [15:0]        max_hits;
    logic [3:0]         density_level;
    logic [6:0]         glyph;
  } out_item_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_DISPATCH, S_MOD_START, S_MOD_RUN, S_VTX,
    S_X_START, S_X_RUN, S_X_DONE, S_Y_START, S_Y_RUN, S_Y_DONE,
    S_PLOT_RD, S_PLOT_WR, S_CELL_RD, S_CELL_GET, S_LVL_START, S_LVL_RUN,
    S_LVL_DONE, S_CLR_INIT, S_CLEAR, S_FIN
  } ctrl_state_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR_INIT, OP_CLR_STEP, OP_MOD_START, OP_DIV_STEP,
    OP_VTX, OP_X_START, OP_X_DONE, OP_Y_START, OP_Y_DONE, OP_PLOT_RD,
    OP_PLOT_WR, OP_CELL_RD, OP_CELL_GET, OP_LVL_START, OP_LVL_DONE, OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       div_last;
    logic       clr_last;
    logic [1:0] mode;
  } dp_status_t;

  // Palette " .:-=+*#%@".
  function automatic logic [6:0] shade_glyph(input logic [3:0] lvl);
    logic [6:0] g;
    unique case (lvl)
      4'd0: g = 7'h20;
      4'd1: g = 7'h2E;
      4'd2: g = 7'h3A;
      4'd3: g = 7'h2D;
      4'd4: g = 7'h3D;
      4'd5: g = 7'h2B;
      4'd6: g = 7'h2A;
      4'd7: g = 7'h23;
      4'd8: g = 7'h25;
      4'd9: g = 7'h40;
      default: g = 7'h20;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cgdg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cgdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 400
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/cgdg_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module cgdg_dp import cgdg_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  output out_item_t                  out_data
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int LVLW  = COUNT_BITS + 4;
  localparam int DIVW  = (LVLW > 31) ? LVLW : 31;
  localparam int DVW   = (COUNT_BITS > 10) ? COUNT_BITS : 10;
  localparam int CW    = $clog2(DIVW);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [7:0]  w0_r, w1_r, w2_r, w0_nxt, w1_nxt, w2_nxt;
  logic [3:0]  num_r, den_r, num_nxt, den_nxt;
  logic [15:0] warm_r, warm_nxt;

  // Walker and grid state.
  logic signed [15:0] px_r, py_r, px_nxt, py_nxt;
  logic [15:0] step_r, step_nxt;
  logic [COUNT_BITS-1:0] max_r, max_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Captured transaction and result fields.
  logic [1:0]  mode_r, mode_nxt;
  logic [30:0] word_r, word_nxt;
  logic [4:0]  row_r, col_r, row_nxt, col_nxt;
  logic [1:0]  vtx_r, vtx_nxt;
  logic        plot_r, plot_nxt;
  logic [COUNT_BITS-1:0] cell_r, cell_nxt;
  logic [3:0]  lvl_r, lvl_nxt;
  logic [6:0]  glyph_r, glyph_nxt;
  out_item_t   out_r, out_nxt;

  // Shared restoring divider.
  logic [DIVW-1:0] quo_r, quo_nxt;
  logic [DVW-1:0]  rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;

  // Combinational helpers.
  logic [9:0]          wsum;
  logic signed [17:0]  tgt_x, tgt_y, cur_t;
  logic signed [15:0]  cur_p;
  logic signed [17:0]  diff;
  logic signed [22:0]  prod;
  logic [21:0]         mag;
  logic signed [23:0]  dq, dsig, moved;
  logic signed [15:0]  sat_p;
  logic [DVW:0]        shifted;
  logic                ge;
  logic                plot_ok, cell_in;
  logic [AW-1:0]       plot_idx, cell_idx;
  logic [LVLW-1:0]     lvl_dvd;
  logic [COUNT_BITS-1:0] bumped;

  // Grid memory ports.
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  cgdg_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Vertex coordinates and arithmetic shared by both axes.
  always_comb begin
    wsum = 10'(w0_r) + 10'(w1_r) + 10'(w2_r);
    unique case (vtx_r)
      VTX_LEFT: begin
        tgt_x = 18'sd0;
        tgt_y = 18'(GRID_HEIGHT - 1);
      end
      VTX_RIGHT: begin
        tgt_x = 18'(GRID_WIDTH - 1);
        tgt_y = 18'(GRID_HEIGHT - 1);
      end
      default: begin
        tgt_x = 18'(GRID_WIDTH / 2);
        tgt_y = 18'sd0;
      end
    endcase
    if (cmd.op == OP_Y_START || cmd.op == OP_Y_DONE) begin
      cur_p = py_r;
      cur_t = tgt_y;
    end else begin
      cur_p = px_r;
      cur_t = tgt_x;
    end
    diff  = cur_t - 18'(cur_p);
    prod  = 23'(diff) * 23'($signed({1'b0, num_r}));
    mag   = prod[22] ? 22'(-prod) : 22'(prod);
    dq    = $signed({2'b00, quo_r[21:0]});
    dsig  = neg_r ? -dq : dq;
    moved = 24'(cur_p) + dsig;
    if (moved > 24'sd32767) begin
      sat_p = 16'sh7FFF;
    end else if (moved < -24'sd32768) begin
      sat_p = 16'sh8000;
    end else begin
      sat_p = moved[15:0];
    end
    shifted  = {rem_r, quo_r[DIVW-1]};
    ge       = shifted >= {1'b0, dvs_r};
    plot_ok  = (step_r >= warm_r) && !px_r[15] && !py_r[15] &&
               (32'(px_r) < GRID_WIDTH) && (32'(py_r) < GRID_HEIGHT);
    plot_idx = AW'(32'(py_r[8:0]) * GRID_WIDTH + 32'(px_r[8:0]));
    cell_in  = (32'(row_r) < GRID_HEIGHT) && (32'(col_r) < GRID_WIDTH);
    cell_idx = AW'(32'(row_r) * GRID_WIDTH + 32'(col_r));
    lvl_dvd  = LVLW'(cell_r) * LVLW'(LEVEL_MAX);
    bumped   = ram_rdata + COUNT_BITS'(1);
  end

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = plot_idx;
    ram_wdata = bumped;
    ram_re    = 1'b0;
    ram_raddr = plot_idx;
    unique case (cmd.op)
      OP_CLR_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      OP_PLOT_RD: ram_re = 1'b1;
      OP_PLOT_WR: ram_we = plot_ok && (ram_rdata != COUNT_MAX);
      OP_CELL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cell_idx;
      end
      default: ;
    endcase
  end

  // Next-state logic of all datapath registers.
  always_comb begin
    w0_nxt = w0_r; w1_nxt = w1_r; w2_nxt = w2_r;
    num_nxt = num_r; den_nxt = den_r; warm_nxt = warm_r;
    px_nxt = px_r; py_nxt = py_r; step_nxt = step_r; max_nxt = max_r;
    clr_addr_nxt = clr_addr_r;
    mode_nxt = mode_r; word_nxt = word_r; row_nxt = row_r; col_nxt = col_r;
    vtx_nxt = vtx_r; plot_nxt = plot_r; cell_nxt = cell_r;
    lvl_nxt = lvl_r; glyph_nxt = glyph_r; out_nxt = out_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r;
    cnt_nxt = cnt_r; neg_nxt = neg_r;

    // Register writes must arrive only while the block is idle; the block itself does not enforce it.
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WEIGHT0:   w0_nxt   = cfg_wdata[7:0];
        CFG_WEIGHT1:   w1_nxt   = cfg_wdata[7:0];
        CFG_WEIGHT2:   w2_nxt   = cfg_wdata[7:0];
        CFG_RATIO_NUM: num_nxt  = cfg_wdata[3:0];
        CFG_RATIO_DEN: den_nxt  = cfg_wdata[3:0];
        CFG_WARMUP:    warm_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (cmd.op)
      OP_LOAD: begin
        mode_nxt  = in_data.mode;
        word_nxt  = in_data.random_word;
        row_nxt   = in_data.cell_row;
        col_nxt   = in_data.cell_col;
        vtx_nxt   = VTX_LEFT;
        plot_nxt  = 1'b0;
        cell_nxt  = '0;
        lvl_nxt   = '0;
        glyph_nxt = '0;
      end
      OP_CLR_INIT: begin
        px_nxt       = 16'(GRID_WIDTH / 2);
        py_nxt       = 16'(GRID_HEIGHT / 2);
        step_nxt     = '0;
        max_nxt      = '0;
        clr_addr_nxt = '0;
      end
      OP_CLR_STEP: begin
        clr_addr_nxt = (clr_addr_r == AW'(CELLS - 1)) ? '0 : clr_addr_r + AW'(1);
      end
      OP_MOD_START: begin
        quo_nxt = DIVW'(word_r);
        dvs_nxt = DVW'(wsum);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        quo_nxt = {quo_r[DIVW-2:0], ge};
        rem_nxt = ge ? DVW'(shifted - {1'b0, dvs_r}) : DVW'(shifted);
        cnt_nxt = cnt_r + CW'(1);
      end
      OP_VTX: begin
        if (wsum == 10'd0) begin
          vtx_nxt = VTX_TOP;
        end else if (rem_r < DVW'(w0_r)) begin
          vtx_nxt = VTX_LEFT;
        end else if (rem_r < DVW'(w0_r) + DVW'(w1_r)) begin
          vtx_nxt = VTX_RIGHT;
        end else begin
          vtx_nxt = VTX_TOP;
        end
      end
      OP_X_START, OP_Y_START: begin
        quo_nxt = DIVW'(mag);
        dvs_nxt = DVW'(den_r);
        rem_nxt = '0;
        cnt_nxt = '0;
        neg_nxt = prod[22];
      end
      OP_X_DONE: begin
        if (den_r != 4'd0) begin
          px_nxt = sat_p;
        end
      end
      OP_Y_DONE: begin
        if (den_r != 4'd0) begin
          py_nxt = sat_p;
        end
      end
      OP_PLOT_WR: begin
        if (plot_ok && ram_rdata != COUNT_MAX) begin
          plot_nxt = 1'b1;
          if (bumped > max_r) begin
            max_nxt = bumped;
          end
        end
        if (step_r != 16'hFFFF) begin
          step_nxt = step_r + 16'd1;
        end
      end
      OP_CELL_GET: begin
        cell_nxt  = cell_in ? ram_rdata : '0;
        glyph_nxt = GLYPH_SPACE;
      end
      OP_LVL_START: begin
        quo_nxt = DIVW'(lvl_dvd);
        dvs_nxt = DVW'(max_r);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_LVL_DONE: begin
        if (cell_r != '0) begin
          if (max_r == '0) begin
            glyph_nxt = GLYPH_HASH;
          end else begin
            lvl_nxt   = (quo_r > DIVW'(LEVEL_MAX)) ? 4'(LEVEL_MAX) : quo_r[3:0];
            glyph_nxt = shade_glyph(lvl_nxt);
          end
        end
      end
      OP_PUBLISH: begin
        out_nxt.chosen_vertex = vtx_r;
        out_nxt.pos_x         = px_r;
        out_nxt.pos_y         = py_r;
        out_nxt.plotted       = plot_r;
        out_nxt.cell_hits     = 16'(cell_r);
        out_nxt.max_hits      = 16'(max_r);
        out_nxt.density_level = lvl_r;
        out_nxt.glyph         = glyph_r;
      end
      default: ;
    endcase
  end

  // Control and architectural state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r       <= WEIGHT_RST;
      w1_r       <= WEIGHT_RST;
      w2_r       <= WEIGHT_RST;
      num_r      <= NUM_RST;
      den_r      <= DEN_RST;
      warm_r     <= WARMUP_RST;
      px_r       <= 16'(GRID_WIDTH / 2);
      py_r       <= 16'(GRID_HEIGHT / 2);
      step_r     <= '0;
      max_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      w0_r       <= w0_nxt;
      w1_r       <= w1_nxt;
      w2_r       <= w2_nxt;
      num_r      <= num_nxt;
      den_r      <= den_nxt;
      warm_r     <= warm_nxt;
      px_r       <= px_nxt;
      py_r       <= py_nxt;
      step_r     <= step_nxt;
      max_r      <= max_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    word_r  <= word_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    vtx_r   <= vtx_nxt;
    plot_r  <= plot_nxt;
    cell_r  <= cell_nxt;
    lvl_r   <= lvl_nxt;
    glyph_r <= glyph_nxt;
    out_r   <= out_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
  end

  assign status.div_last = (cnt_r == CW'(DIVW - 1));
  assign status.clr_last = (clr_addr_r == AW'(CELLS - 1));
  assign status.mode     = mode_r;
  assign out_data        = out_r;

endmodule

`default_nettype wire

>>> rtl/cgdg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cgdg_ctrl import cgdg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        publish;

  assign in_ready = (state_r == S_IDLE);
  assign publish  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BOOT:      if (status.clr_last) state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (status.mode)
          MODE_STEP:  state_nxt = S_MOD_START;
          MODE_READ:  state_nxt = S_CELL_RD;
          MODE_CLEAR: state_nxt = S_CLR_INIT;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_MOD_START: state_nxt = S_MOD_RUN;
      S_MOD_RUN:   if (status.div_last) state_nxt = S_VTX;
      S_VTX:       state_nxt = S_X_START;
      S_X_START:   state_nxt = S_X_RUN;
      S_X_RUN:     if (status.div_last) state_nxt = S_X_DONE;
      S_X_DONE:    state_nxt = S_Y_START;
      S_Y_START:   state_nxt = S_Y_RUN;
      S_Y_RUN:     if (status.div_last) state_nxt = S_Y_DONE;
      S_Y_DONE:    state_nxt = S_PLOT_RD;
      S_PLOT_RD:   state_nxt = S_PLOT_WR;
      S_PLOT_WR:   state_nxt = S_FIN;
      S_CELL_RD:   state_nxt = S_CELL_GET;
      S_CELL_GET:  state_nxt = S_LVL_START;
      S_LVL_START: state_nxt = S_LVL_RUN;
      S_LVL_RUN:   if (status.div_last) state_nxt = S_LVL_DONE;
      S_LVL_DONE:  state_nxt = S_FIN;
      S_CLR_INIT:  state_nxt = S_CLEAR;
      S_CLEAR:     if (status.clr_last) state_nxt = S_FIN;
      S_FIN:       if (publish) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath command for each state.
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_BOOT, S_CLEAR:             cmd.op = OP_CLR_STEP;
      S_IDLE:                      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_MOD_START:                 cmd.op = OP_MOD_START;
      S_MOD_RUN, S_X_RUN, S_Y_RUN,
      S_LVL_RUN:                   cmd.op = OP_DIV_STEP;
      S_VTX:                       cmd.op = OP_VTX;
      S_X_START:                   cmd.op = OP_X_START;
      S_X_DONE:                    cmd.op = OP_X_DONE;
      S_Y_START:                   cmd.op = OP_Y_START;
      S_Y_DONE:                    cmd.op = OP_Y_DONE;
      S_PLOT_RD:                   cmd.op = OP_PLOT_RD;
      S_PLOT_WR:                   cmd.op = OP_PLOT_WR;
      S_CELL_RD:                   cmd.op = OP_CELL_RD;
      S_CELL_GET:                  cmd.op = OP_CELL_GET;
      S_LVL_START:                 cmd.op = OP_LVL_START;
      S_LVL_DONE:                  cmd.op = OP_LVL_DONE;
      S_CLR_INIT:                  cmd.op = OP_CLR_INIT;
      S_FIN:                       cmd.op = publish ? OP_PUBLISH : OP_NONE;
      default:                     cmd.op = OP_NONE;
    endcase
  end

  // Result slot occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/chaos_game_density_grid.sv
// Chaos-game point plotter over a grid of saturating hit counters.
// Input channel (in_valid/in_ready/in_data) takes one transaction per item:
// mode 0 steps the point toward a weighted random vertex and may plot it,
// mode 1 reads one cell with its density glyph, mode 2 clears and restarts.
// Result channel (out_valid/out_ready/out_data) returns one transaction per
// item. Registers are written on cfg_we with cfg_idx/cfg_wdata; the user is
// to write them only while idle; the block itself does not enforce it.
// Items are worked one at a time on a shared one-bit-per-cycle divider of
// DIVW = max(31, COUNT_BITS+4) steps: three runs for a step (vertex, x, y),
// one for a read, none for a clear or for the unused mode 3.
// The result sits in an output register, so the next transaction is taken
// while a result waits; a stalled receiver only holds the block once a
// second result is ready to be published.
// After reset a clearing pass writes every grid cell to zero, one cell per
// cycle; in_ready stays low meanwhile, register writes are still taken.
`timescale 1ns / 1ps
`default_nettype none

module chaos_game_density_grid import cgdg_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cgdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cgdg_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

`include "chaos_game_density_grid_assert.svh"

  // The grid is never being cleared while a transaction can enter.
`CGDG_ASSERT_SAME(a_no_accept_in_clear, cmd.op == OP_CLR_STEP, !in_ready, "accept during clear")
  // A result is published only into a free or draining output slot.
`CGDG_ASSERT_SAME(a_publish_slot, cmd.op == OP_PUBLISH, !out_valid || out_ready, "result overwritten")
  // An accepted transaction keeps the block busy on the next cycle.
`CGDG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "double accept")

endmodule

`default_nettype wire

>>> bench/chaos_game_density_grid_tb.sv
`timescale 1ns / 1ps

module chaos_game_density_grid_tb;
  import cgdg_pkg::*;

  localparam int GW = GRID_WIDTH_DEF;
  localparam int GH = GRID_HEIGHT_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  chaos_game_density_grid dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Mirror of the block's registers and state.
  logic [7:0] wt0, wt1, wt2;
  logic [3:0] approach_num, approach_den;
  logic [15:0] warmup_len;
  int pt_x, pt_y;
  int unsigned steps_done;
  int unsigned grid_hits [GW*GH];
  int unsigned peak_hits;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int fail_count = 0;
  int n_step = 0, n_read = 0, n_clear = 0, n_plot = 0, n_lit = 0;
  bit idling_on = 1'b1;

  function automatic int move_toward(int p, int t);
    longint d;
    if (approach_den == 0) return p;
    d = longint'(t - p) * longint'(approach_num);
    d = d / longint'(approach_den);
    d = d + p;
    if (d > 32767) return 32767;
    if (d < -32768) return -32768;
    return int'(d);
  endfunction

  function automatic void restart_grid();
    pt_x = GW / 2;
    pt_y = GH / 2;
    steps_done = 0;
    peak_hits = 0;
    foreach (grid_hits[i]) grid_hits[i] = 0;
  endfunction

  // Work out the result of one transaction and advance the mirrored state.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int unsigned wsum, pick, idx, lvl;
    int tx, ty;
    r = '0;
    case (it.mode)
      MODE_STEP: begin
        wsum = wt0 + wt1 + wt2;
        if (wsum == 0) begin
          r.chosen_vertex = VTX_TOP;
        end else begin
          pick = it.random_word % wsum;
          if (pick < wt0) r.chosen_vertex = VTX_LEFT;
          else if (pick < wt0 + wt1) r.chosen_vertex = VTX_RIGHT;
          else r.chosen_vertex = VTX_TOP;
        end
        case (r.chosen_vertex)
          VTX_LEFT: begin tx = 0; ty = GH - 1; end
          VTX_RIGHT: begin tx = GW - 1; ty = GH - 1; end
          default: begin tx = GW / 2; ty = 0; end
        endcase
        pt_x = move_toward(pt_x, tx);
        pt_y = move_toward(pt_y, ty);
        if (steps_done >= warmup_len && pt_x >= 0 && pt_x < GW && pt_y >= 0 && pt_y < GH)
        begin
          idx = pt_y * GW + pt_x;
          if (grid_hits[idx] < 65535) begin
            grid_hits[idx]++;
            r.plotted = 1'b1;
            if (grid_hits[idx] > peak_hits) peak_hits = grid_hits[idx];
          end
        end
        if (steps_done < 65535) steps_done++;
      end
      MODE_READ: begin
        r.glyph = GLYPH_SPACE;
        if (it.cell_row < GH && it.cell_col < GW) begin
          r.cell_hits = 16'(grid_hits[it.cell_row * GW + it.cell_col]);
          if (r.cell_hits != 0) begin
            if (peak_hits == 0) begin
              r.glyph = GLYPH_HASH;
            end else begin
              lvl = (r.cell_hits * 9) / peak_hits;
              if (lvl > 9) lvl = 9;
              r.density_level = 4'(lvl);
              case (lvl)
                0: r.glyph = 7'(" ");
                1: r.glyph = 7'(".");
                2: r.glyph = 7'(":");
                3: r.glyph = 7'("-");
                4: r.glyph = 7'("=");
                5: r.glyph = 7'("+");
                6: r.glyph = 7'("*");
                7: r.glyph = 7'("#");
                8: r.glyph = 7'("%");
                default: r.glyph = 7'("@");
              endcase
            end
          end
        end
      end
      MODE_CLEAR: restart_grid();
      default: ;
    endcase
    r.pos_x = pt_x[15:0];
    r.pos_y = pt_y[15:0];
    r.max_hits = peak_hits[15:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (!idling_on || roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: present queued transactions at the falling edge.
  bit in_took = 1'b0;
  int in_gap = 0;
  always @(negedge clk) begin
    if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= pending_items.pop_front();
      in_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver back-pressure.
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_gap <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Monitor: predict on input acceptance, compare on result acceptance.
  always @(posedge clk) begin
    out_item_t want;
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(predict_result(in_data));
      case (in_data.mode)
        MODE_STEP: n_step++;
        MODE_READ: n_read++;
        MODE_CLEAR: n_clear++;
        default: ;
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction arrived with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.plotted === 1'b1) n_plot++;
        if (out_data.density_level !== 4'd0) n_lit++;
        check_field("chosen_vertex", want.chosen_vertex, out_data.chosen_vertex);
        check_field("pos_x", want.pos_x, out_data.pos_x);
        check_field("pos_y", want.pos_y, out_data.pos_y);
        check_field("plotted", want.plotted, out_data.plotted);
        check_field("cell_hits", want.cell_hits, out_data.cell_hits);
        check_field("max_hits", want.max_hits, out_data.max_hits);
        check_field("density_level", want.density_level, out_data.density_level);
        check_field("glyph", want.glyph, out_data.glyph);
      end
    end
  end

  // Wait at clock edges until nothing is in flight, then let the block settle.
  task automatic drain();
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_WEIGHT0: wt0 = val[7:0];
      CFG_WEIGHT1: wt1 = val[7:0];
      CFG_WEIGHT2: wt2 = val[7:0];
      CFG_RATIO_NUM: approach_num = val[3:0];
      CFG_RATIO_DEN: approach_den = val[3:0];
      default: warmup_len = val[15:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int w0, int w1, int w2, int num, int den, int warm);
    drain();
    write_reg(CFG_WEIGHT0, w0);
    write_reg(CFG_WEIGHT1, w1);
    write_reg(CFG_WEIGHT2, w2);
    write_reg(CFG_RATIO_NUM, num);
    write_reg(CFG_RATIO_DEN, den);
    write_reg(CFG_WARMUP, warm);
  endtask

  function automatic in_item_t make_item(logic [1:0] m, int w, int r, int c);
    in_item_t it;
    it.mode = m;
    it.random_word = 31'(w);
    it.cell_row = 5'(r);
    it.cell_col = 5'(c);
    return it;
  endfunction

  // Mostly steps with random content, then reads, occasional clears and unused codes.
  task automatic queue_random(int count);
    int roll;
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      it.random_word = 31'($urandom());
      it.cell_row = 5'($urandom_range(0, 19));
      it.cell_col = 5'($urandom_range(0, 19));
      if (roll < 70) begin
        it.mode = MODE_STEP;
      end else if (roll < 93) begin
        it.mode = MODE_READ;
        if ($urandom_range(0, 9) == 0) begin
          it.cell_row = 5'($urandom());
          it.cell_col = 5'($urandom());
        end
      end else if (roll < 97) begin
        it.mode = MODE_CLEAR;
      end else begin
        it.mode = MODE_UNUSED;
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    int den;
    wt0 = WEIGHT_RST; wt1 = WEIGHT_RST; wt2 = WEIGHT_RST;
    approach_num = NUM_RST;
    approach_den = DEN_RST;
    warmup_len = WARMUP_RST;
    restart_grid();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, warmup boundary, reads at the grid edges and beyond.
    for (int i = 0; i < 12; i++)
      pending_items.push_back(make_item(MODE_STEP, (i == 0) ? 32'h7FFFFFFF : i * 7, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 0, 19, 19));
    pending_items.push_back(make_item(MODE_READ, 0, 31, 31));
    pending_items.push_back(make_item(MODE_READ, 0, 19, 20));
    pending_items.push_back(make_item(MODE_READ, 0, 10, 10));
    pending_items.push_back(make_item(MODE_UNUSED, 32'h7FFFFFFF, 31, 31));
    pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 0, 10, 10));
    queue_random(80);

    // All weights zero, steep ratio: top vertex only and coordinate saturation.
    set_config(0, 0, 0, 15, 1, 0);
    for (int i = 0; i < 6; i++) pending_items.push_back(make_item(MODE_STEP, $urandom(), 0, 0));
    queue_random(30);

    // Full weights, zero numerator, longest warmup.
    set_config(255, 255, 255, 0, 15, 65535);
    pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0));
    queue_random(40);

    // Zero denominator: the point never moves.
    set_config(255, 0, 128, 15, 0, 0);
    queue_random(40);

    // Overshooting ratio drives the point off the grid.
    set_config(3, 5, 7, 15, 4, 2);
    pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0));
    queue_random(60);

    // Random settings, mostly staying inside the grid.
    for (int ph = 0; ph < 10; ph++) begin
      idling_on = (ph % 3) != 2;
      den = $urandom_range(1, 15);
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, den), den, $urandom_range(0, 20));
      pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0));
      queue_random(100);
    end

    drain();
    $display("Covered %0d steps (%0d plotted), %0d reads (%0d with nonzero level), %0d clears.",
             n_step, n_plot, n_read, n_lit, n_clear);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out waiting for results.");
    $display("Verification failed");
    $finish;
  end

endmodule

>>> chaos_game_density_grid.f
+incdir+rtl
rtl/cgdg_pkg.sv
rtl/cgdg_ram.sv
rtl/cgdg_dp.sv
rtl/cgdg_ctrl.sv
rtl/chaos_game_density_grid.sv
bench/chaos_game_density_grid_tb.sv
